// File: hdl/u8nt_pkg.sv
// Shared constants and types for the 8N1 UART transceiver with start-edge timeout.
package u8nt_pkg;

  localparam int DATA_BITS  = 8;
  localparam int FRAME_BITS = DATA_BITS + 2;

  localparam int PERIOD_W   = 16;
  localparam int LIMIT_W    = 32;
  localparam int RX_TICK_W  = 20;
  localparam int BITS_W     = 4;
  localparam int TARGET_W   = RX_TICK_W + 1;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd104;
  localparam logic [LIMIT_W-1:0]  TIMEOUT_RESET    = 32'h7fff_f000;

  // configuration register indexes
  localparam logic CFG_BIT_PERIOD = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic level;
    logic busy;
  } tx_out_t;

  typedef struct packed {
    logic       busy;
    logic       valid;
    logic [7:0] data;
    logic       timed_out;
  } rx_out_t;

endpackage

// File: hdl/u8nt_tx.sv
// Transmit side: frame shifter and bit timer, one line tick per advance.
module u8nt_tx (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          send_request,
  input  logic [7:0]                    send_byte,
  input  logic [u8nt_pkg::PERIOD_W-1:0] bit_period,
  output u8nt_pkg::tx_out_t             tx_out
);

  logic [u8nt_pkg::FRAME_BITS-1:0] shift, shift_next, shift_ld;
  logic [u8nt_pkg::PERIOD_W-1:0]   tick, tick_next, tick_ld, tick_inc;
  logic                            load;
  logic                            busy;

  always_comb begin
    load     = (shift == '0) && send_request;
    shift_ld = load ? {1'b1, send_byte[u8nt_pkg::DATA_BITS-1:0], 1'b0} : shift;
    tick_ld  = load ? '0 : tick;
    busy     = (shift_ld != '0);
    tick_inc = tick_ld + 1'b1;
    shift_next = shift_ld;
    tick_next  = tick_ld;
    if (busy) begin
      // a wrapped count also ends the bit; periods of 0 and 1 hold one tick
      if ((tick_inc >= bit_period) || (tick_inc == '0)) begin
        shift_next = shift_ld >> 1;
        tick_next  = '0;
      end else begin
        tick_next = tick_inc;
      end
    end
    tx_out.busy  = busy;
    tx_out.level = busy ? shift_ld[0] : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= '0;
      tick  <= '0;
    end else if (adv) begin
      shift <= shift_next;
      tick  <= tick_next;
    end
  end

endmodule

// File: hdl/u8nt_rx.sv
// Receive side: arm, wait for idle, wait for start edge with timeout, sample data bits.
module u8nt_rx (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          rx_level,
  input  logic                          receive_request,
  input  logic [u8nt_pkg::PERIOD_W-1:0] bit_period,
  input  logic [u8nt_pkg::LIMIT_W-1:0]  edge_timeout_limit,
  output u8nt_pkg::rx_out_t             rx_out
);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_WAIT_HIGH = 2'd1;
  localparam logic [1:0] PH_WAIT_EDGE = 2'd2;
  localparam logic [1:0] PH_SAMPLE    = 2'd3;

  logic [1:0]                       phase, phase_next, phase_ld;
  logic [u8nt_pkg::RX_TICK_W-1:0]   tick, tick_next, tick_ld, tick_inc;
  logic [u8nt_pkg::LIMIT_W-1:0]     wait_cnt, wait_next, wait_ld, wait_inc;
  logic [7:0]                       shift, shift_next, shift_ld;
  logic [u8nt_pkg::BITS_W-1:0]      bits, bits_next, bits_ld, bits_inc;
  logic [u8nt_pkg::BITS_W:0]        bits_p1;
  logic [u8nt_pkg::TARGET_W-1:0]    target;
  logic                             arm;
  logic                             valid;
  logic                             timed_out;

  always_comb begin
    arm      = (phase == PH_IDLE) && receive_request;
    phase_ld = arm ? PH_WAIT_HIGH : phase;
    tick_ld  = arm ? '0 : tick;
    wait_ld  = arm ? '0 : wait_cnt;
    shift_ld = arm ? '0 : shift;
    bits_ld  = arm ? '0 : bits;

    phase_next = phase_ld;
    tick_next  = tick_ld;
    wait_next  = wait_ld;
    shift_next = shift_ld;
    bits_next  = bits_ld;
    valid      = 1'b0;
    timed_out  = 1'b0;

    wait_inc = (wait_ld == '1) ? wait_ld : wait_ld + 1'b1;
    tick_inc = tick_ld + 1'b1;
    bits_inc = bits_ld + 1'b1;
    bits_p1  = {1'b0, bits_ld} + 1'b1;
    // sample point: half a bit, plus one bit for the start bit, plus one bit per data bit already taken
    target   = {{(u8nt_pkg::TARGET_W-u8nt_pkg::PERIOD_W+1){1'b0}}, bit_period[15:1]}
             + ({{(u8nt_pkg::TARGET_W-u8nt_pkg::PERIOD_W){1'b0}}, bit_period}
                * {{(u8nt_pkg::TARGET_W-u8nt_pkg::BITS_W-1){1'b0}}, bits_p1});

    unique case (phase_ld)
      PH_IDLE: begin
      end
      PH_WAIT_HIGH: begin
        if (rx_level) begin
          phase_next = PH_WAIT_EDGE;
          wait_next  = '0;
        end
      end
      PH_WAIT_EDGE: begin
        if (!rx_level) begin
          phase_next = PH_SAMPLE;
          tick_next  = '0;
          shift_next = '0;
          bits_next  = '0;
        end else begin
          wait_next = wait_inc;
          if (wait_inc > edge_timeout_limit) begin
            timed_out  = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_SAMPLE: begin
        tick_next = tick_inc;
        if ({1'b0, tick_inc} >= target) begin
          if (rx_level && (bits_ld < 4'd8)) begin
            shift_next[bits_ld[2:0]] = 1'b1;
          end
          bits_next = bits_inc;
          if (bits_inc >= u8nt_pkg::BITS_W'(u8nt_pkg::DATA_BITS)) begin
            valid      = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    rx_out.busy      = (phase_next != PH_IDLE);
    rx_out.valid     = valid;
    rx_out.data      = valid ? shift_next : 8'd0;
    rx_out.timed_out = timed_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      tick     <= '0;
      wait_cnt <= '0;
      shift    <= '0;
      bits     <= '0;
    end else if (adv) begin
      phase    <= phase_next;
      tick     <= tick_next;
      wait_cnt <= wait_next;
      shift    <= shift_next;
      bits     <= bits_next;
    end
  end

endmodule

// File: hdl/uart_8n1_transceiver_with_timeout_core.sv
// Top level: input register, transmit and receive logic, result register, config registers.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: one line tick with requests
//   m_*      out  m_tvalid/m_tready  m_tdata: line levels and status for that tick
//   cfg_*    in   cfg_wen            cfg_addr selects register, cfg_wdata value
//
// One word per cycle while m_tready stays high; m_tdata is registered after the tick work.
// All tick work sits between the input register and the result register.
// s_tready drops only while both registers are full and m_tready is low.
// Reset clears the control state and loads the register defaults; no clearing pass.
module uart_8n1_transceiver_with_timeout_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] rx_level, [1] send_request, [9:2] send_byte, [10] receive_request
  input  logic [u8nt_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] tx_level, [1] tx_busy, [2] rx_busy, [3] rx_valid, [11:4] rx_data,
  // [12] rx_timed_out
  output logic [u8nt_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_wen,
  input  logic                                cfg_addr,
  input  logic [u8nt_pkg::LIMIT_W-1:0]        cfg_wdata
);

  logic [u8nt_pkg::PERIOD_W-1:0] bit_period;
  logic [u8nt_pkg::LIMIT_W-1:0]  edge_timeout_limit;

  logic       in_valid;
  logic       in_rx_level;
  logic       in_send_request;
  logic [7:0] in_send_byte;
  logic       in_receive_request;

  logic              out_free;
  logic              adv;
  u8nt_pkg::tx_out_t tx_out;
  u8nt_pkg::rx_out_t rx_out;

  assign out_free = !m_tvalid || m_tready;
  assign adv      = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period         <= u8nt_pkg::BIT_PERIOD_RESET;
      edge_timeout_limit <= u8nt_pkg::TIMEOUT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        u8nt_pkg::CFG_BIT_PERIOD: bit_period         <= cfg_wdata[u8nt_pkg::PERIOD_W-1:0];
        u8nt_pkg::CFG_TIMEOUT:    edge_timeout_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_rx_level        <= s_tdata[0];
      in_send_request    <= s_tdata[1];
      in_send_byte       <= s_tdata[9:2];
      in_receive_request <= s_tdata[10];
    end
  end

  u8nt_tx u_tx (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .send_request (in_send_request),
    .send_byte    (in_send_byte),
    .bit_period   (bit_period),
    .tx_out       (tx_out)
  );

  u8nt_rx u_rx (
    .clk                (clk),
    .rst                (rst),
    .adv                (adv),
    .rx_level           (in_rx_level),
    .receive_request    (in_receive_request),
    .bit_period         (bit_period),
    .edge_timeout_limit (edge_timeout_limit),
    .rx_out             (rx_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {3'b000, rx_out.timed_out, rx_out.data, rx_out.valid, rx_out.busy,
                  tx_out.busy, tx_out.level};
    end
  end

endmodule

// File: hdl/u8nt_checker.sv
// Port-level checks for the UART transceiver top level, bound to it.
module u8nt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [u8nt_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // input stalls only when the result side is full and held
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while result side can move");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

  // a finished byte leaves the receiver idle and is never a timeout too
  a_rx_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> (!m_tdata[2] && !m_tdata[12]))
    else $error("rx_valid with rx_busy or rx_timed_out");

  a_rx_data_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[3]) |-> (m_tdata[11:4] == 8'd0))
    else $error("rx_data nonzero without rx_valid");

  a_tx_idle_high: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> m_tdata[0])
    else $error("tx line low while transmitter idle");

endmodule

bind uart_8n1_transceiver_with_timeout_core u8nt_checker u_u8nt_checker (.*);

// File: bench/uart_tick_checker.sv
// Checker for the UART core: per-tick prediction of line status and comparison of result words.
module uart_tick_checker
  import u8nt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wen,
  input  logic                   cfg_addr,
  input  logic [LIMIT_W-1:0]     cfg_wdata,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0] pad;
    logic       receive_request;
    logic [7:0] send_byte;
    logic       send_request;
    logic       rx_level;
  } line_in_t;

  typedef struct packed {
    logic [2:0] pad;
    logic       timed_out;
    logic [7:0] data;
    logic       valid;
    logic       rx_busy;
    logic       tx_busy;
    logic       tx_level;
  } line_status_t;

  typedef enum logic [1:0] {RX_IDLE, RX_WAIT_HIGH, RX_WAIT_EDGE, RX_SAMPLE} rx_state_t;

  logic [PERIOD_W-1:0]  period;
  logic [LIMIT_W-1:0]   edge_limit;
  logic [9:0]           tx_frame;
  logic [15:0]          tx_ticks;
  rx_state_t            rx_state;
  logic [RX_TICK_W-1:0] rx_ticks;
  logic [31:0]          rx_waited;
  logic [7:0]           rx_byte;
  logic [BITS_W-1:0]    rx_nbits;

  line_status_t expected_status_q[$];

  // one line tick of the transceiver
  task automatic line_tick(input line_in_t w, output line_status_t r);
    logic [31:0] target;
    r = '0;
    if (tx_frame == '0 && w.send_request) begin
      tx_frame = {1'b1, w.send_byte, 1'b0};
      tx_ticks = '0;
    end
    r.tx_busy  = (tx_frame != '0);
    r.tx_level = r.tx_busy ? tx_frame[0] : 1'b1;
    if (r.tx_busy) begin
      tx_ticks = tx_ticks + 16'd1;
      if (tx_ticks >= period || tx_ticks == '0) begin
        tx_frame = tx_frame >> 1;
        tx_ticks = '0;
      end
    end

    if (rx_state == RX_IDLE && w.receive_request) begin
      rx_state  = RX_WAIT_HIGH;
      rx_waited = '0;
      rx_ticks  = '0;
      rx_byte   = '0;
      rx_nbits  = '0;
    end
    case (rx_state)
      RX_WAIT_HIGH: begin
        if (w.rx_level) begin
          rx_state  = RX_WAIT_EDGE;
          rx_waited = '0;
        end
      end
      RX_WAIT_EDGE: begin
        if (!w.rx_level) begin
          rx_state = RX_SAMPLE;
          rx_ticks = '0;
          rx_byte  = '0;
          rx_nbits = '0;
        end else begin
          // count saturates, so the all-ones limit never fires
          if (rx_waited != '1) rx_waited = rx_waited + 32'd1;
          if (rx_waited > edge_limit) begin
            r.timed_out = 1'b1;
            rx_state    = RX_IDLE;
          end
        end
      end
      RX_SAMPLE: begin
        target   = 32'(period >> 1) + (32'(rx_nbits) + 32'd1) * 32'(period);
        rx_ticks = rx_ticks + 1'b1;
        if (32'(rx_ticks) >= target) begin
          if (w.rx_level && rx_nbits < 4'd8) rx_byte[rx_nbits[2:0]] = 1'b1;
          rx_nbits = rx_nbits + 1'b1;
          if (rx_nbits >= BITS_W'(DATA_BITS)) begin
            r.valid  = 1'b1;
            r.data   = rx_byte;
            rx_state = RX_IDLE;
          end
        end
      end
      default: ;
    endcase
    r.rx_busy = (rx_state != RX_IDLE);
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin : watch
    line_status_t want;
    line_status_t got;
    if (rst) begin
      period     = BIT_PERIOD_RESET;
      edge_limit = TIMEOUT_RESET;
      tx_frame   = '0;
      tx_ticks   = '0;
      rx_state   = RX_IDLE;
      rx_ticks   = '0;
      rx_waited  = '0;
      rx_byte    = '0;
      rx_nbits   = '0;
      expected_status_q.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_addr == CFG_BIT_PERIOD) period = cfg_wdata[PERIOD_W-1:0];
        else if (cfg_addr == CFG_TIMEOUT) edge_limit = cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        line_tick(line_in_t'(s_tdata), want);
        expected_status_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = line_status_t'(m_tdata);
        if (expected_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          want = expected_status_q.pop_front();
          if (got.tx_level !== want.tx_level || got.tx_busy !== want.tx_busy ||
              got.rx_busy !== want.rx_busy || got.valid !== want.valid ||
              got.data !== want.data || got.timed_out !== want.timed_out ||
              got.pad !== want.pad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: tx_level %b/%b tx_busy %b/%b rx_busy %b/%b ",
                        "rx_valid %b/%b rx_data %h/%h rx_timed_out %b/%b pad %b/%b ",
                        "(expected/actual)"},
                       want.tx_level, got.tx_level, want.tx_busy, got.tx_busy,
                       want.rx_busy, got.rx_busy, want.valid, got.valid,
                       want.data, got.data, want.timed_out, got.timed_out,
                       want.pad, got.pad);
          end
        end
      end
    end
    outstanding = expected_status_q.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the UART core bench: clock, reset, tick stimulus, result-side stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import u8nt_pkg::*;

  localparam int HOLD_CYCLES = 80;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tready  = 1'b0;
  logic                   cfg_wen   = 1'b0;
  logic                   cfg_addr  = CFG_BIT_PERIOD;
  logic [LIMIT_W-1:0]     cfg_wdata = '0;
  wire                    s_tready;
  wire                    m_tvalid;
  wire [OUT_TDATA_W-1:0]  m_tdata;
  int                     mismatches;
  int                     outstanding;
  bit                     hold_go = 1'b0;
  logic [PERIOD_W-1:0]    line_period = BIT_PERIOD_RESET;
  logic                   rx_line_q[$];

  always #5 clk = ~clk;

  uart_8n1_transceiver_with_timeout_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  uart_tick_checker line_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_tick(input logic level, input logic send, input logic [7:0] value,
                           input logic arm, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {5'b0, arm, value, send, level};
    s_tvalid <= 1'b1;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // upper half of the period word is don't-care for the block
  task automatic set_line_config(input logic [PERIOD_W-1:0] per, input logic [31:0] limit);
    cfg_addr  <= CFG_BIT_PERIOD;
    cfg_wdata <= {16'($urandom), per};
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_addr  <= CFG_TIMEOUT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    line_period = per;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // serial line seen by the receiver: mostly proper frames for periods up to 32, else idle runs and noise
  task automatic refill_line();
    int p, r, run;
    logic [7:0] b;
    p = (line_period < 2) ? 1 : int'(line_period);
    r = $urandom_range(0, 99);
    if (line_period <= 32 && r < 60) begin
      b = 8'($urandom);
      repeat ($urandom_range(1, 4)) rx_line_q.push_back(1'b1);
      repeat (p) rx_line_q.push_back(1'b0);
      for (int i = 0; i < 8; i++) repeat (p) rx_line_q.push_back(b[i]);
      repeat (p) rx_line_q.push_back(1'b1);
    end else if (r < 85) begin
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
      repeat (run) rx_line_q.push_back(1'b1);
    end else begin
      repeat ($urandom_range(1, 8)) rx_line_q.push_back(1'($urandom));
    end
  endtask

  task automatic random_ticks(input int count, input bit dense);
    logic level;
    for (int i = 0; i < count; i++) begin
      if (rx_line_q.size() == 0) refill_line();
      level = rx_line_q.pop_front();
      send_tick(level, $urandom_range(0, 4) == 0, 8'($urandom),
                $urandom_range(0, 5) == 0, dense ? 0 : pick_gap());
    end
  endtask

  // result side: ready runs and stalls, plus one long hold-off on request
  initial begin : sink
    int left;
    int r;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        m_tready <= 1'b0;
        left = HOLD_CYCLES;
      end else if (left > 0) begin
        left--;
      end else if (m_tready) begin
        r = $urandom_range(0, 99);
        m_tready <= 1'b0;
        left = (r < 70) ? $urandom_range(0, 2) :
               (r < 95) ? $urandom_range(3, 9) : $urandom_range(20, 40);
      end else begin
        m_tready <= 1'b1;
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 29);
      end
    end
  end

  initial begin : stimulus
    logic [PERIOD_W-1:0] per;
    logic [31:0] limit;
    int count;
    bit dense;
    logic [7:0] pattern;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-tick bits, zero timeout
    set_line_config(16'd1, 32'd0);
    send_tick(1'b0, 1'b1, 8'hFF, 1'b1, 0);  // armed with line low: waits for high
    send_tick(1'b0, 1'b1, 8'h00, 1'b0, 0);  // send while busy is dropped
    send_tick(1'b1, 1'b0, 8'h00, 1'b0, 0);
    send_tick(1'b1, 1'b0, 8'h00, 1'b1, 0);  // timeout on first high tick in edge wait
    repeat (8) send_tick(1'b1, 1'b0, 8'h00, 1'b0, 0);
    send_tick(1'b1, 1'b1, 8'h00, 1'b1, 0);
    send_tick(1'b0, 1'b0, 8'h00, 1'b1, 0);  // start edge, arm while busy
    pattern = 8'hA6;
    for (int i = 0; i < 8; i++) send_tick(pattern[i], 1'b0, 8'h00, 1'b0, 0);
    send_tick(1'b1, 1'b0, 8'h00, 1'b0, 0);
    drain_results();

    // zero bit period, endless edge wait
    set_line_config(16'd0, 32'hFFFF_FFFF);
    send_tick(1'b1, 1'b1, 8'h80, 1'b1, 0);
    repeat (6) send_tick(1'b1, 1'b0, 8'h00, 1'b0, 0);
    send_tick(1'b0, 1'b0, 8'h00, 1'b0, 0);
    pattern = 8'h5B;
    for (int i = 0; i < 8; i++) send_tick(pattern[i], 1'b0, 8'h00, 1'b0, 0);
    send_tick(1'b1, 1'b0, 8'h00, 1'b0, 0);
    drain_results();

    for (int ph = 0; ph < 12; ph++) begin
      count = 55;
      dense = ($urandom_range(0, 3) == 0);
      case (ph)
        0: begin per = 16'd2; limit = 32'd0; end
        1: begin per = 16'hFFFF; limit = 32'hFFFF_FFFF; count = 30; end
        2: begin per = BIT_PERIOD_RESET; limit = TIMEOUT_RESET; count = 30; end
        default: begin
          per = 16'($urandom_range(2, 12));
          case ($urandom_range(0, 2))
            0: limit = 32'd0;
            1: limit = $urandom_range(1, 40);
            default: limit = $urandom_range(40, 400);
          endcase
        end
      endcase
      rx_line_q.delete();
      set_line_config(per, limit);
      if (ph == 4) begin
        hold_go = 1'b1;
        dense = 1'b1;
      end
      random_ticks(count, dense);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
